@@ sv/mnss_pkg.sv @@
// ----------------------------------------------------------------------------
// mnss_pkg
// Shared types and constants of the Markov next-state sampler.
// ----------------------------------------------------------------------------
package mnss_pkg;

   // Defaults of the top-level parameters
   localparam int DEFAULT_STATES             = 16;
   localparam int DEFAULT_PROB_FRACTION_BITS = 16;

   // Fixed field widths of the item channels
   localparam int OP_BITS    = 1;
   localparam int ROW_BITS   = 4;
   localparam int PROB_BITS  = 17;
   localparam int ALPHA_BITS = 16;
   localparam int NEXT_BITS  = 4;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_WRITE  = 1'b0;
   localparam logic [OP_BITS-1:0] OP_SAMPLE = 1'b1;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_HOLD
   } ctrl_state_type;

   // Walk unit status towards the sequencer
   typedef struct packed {
      logic                 done;
      logic [NEXT_BITS-1:0] next_state;
      logic                 fell_through;
   } walk_status_type;

endpackage

@@ sv/mnss_if.sv @@
// ----------------------------------------------------------------------------
// mnss_if
// Valid/ready channels of the sampler: request items and response items.
// ----------------------------------------------------------------------------
interface mnss_req_if;
   logic                           valid;
   logic                           ready;
   logic [mnss_pkg::OP_BITS-1:0]    operation;
   logic [mnss_pkg::ROW_BITS-1:0]   row_state;
   logic [mnss_pkg::ROW_BITS-1:0]   column_state;
   logic [mnss_pkg::PROB_BITS-1:0]  probability;
   logic [mnss_pkg::ALPHA_BITS-1:0] alpha;

   modport source (
      output valid, operation, row_state, column_state, probability, alpha,
      input  ready
   );
   modport sink (
      input  valid, operation, row_state, column_state, probability, alpha,
      output ready
   );
endinterface

interface mnss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mnss_pkg::NEXT_BITS-1:0] next_state;
   logic                          fell_through;

   modport source (
      output valid, next_state, fell_through,
      input  ready
   );
   modport sink (
      input  valid, next_state, fell_through,
      output ready
   );
endinterface

@@ sv/mnss_table.sv @@
// ----------------------------------------------------------------------------
// mnss_table
// Transition table memory: one write port, one registered read port, and a
// sweep after reset that loads the identity matrix.
// ----------------------------------------------------------------------------
module mnss_table #(
   parameter int STATES             = mnss_pkg::DEFAULT_STATES,
   parameter int PROB_FRACTION_BITS = mnss_pkg::DEFAULT_PROB_FRACTION_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [2*$clog2(STATES)-1:0]   wr_addr,
   input  logic [PROB_FRACTION_BITS:0]   wr_data,
   input  logic                          rd_en,
   input  logic [2*$clog2(STATES)-1:0]   rd_addr,
   output logic [PROB_FRACTION_BITS:0]   rd_data,
   output logic                          busy
);

   localparam int COL_BITS  = $clog2(STATES);
   localparam int ADDR_BITS = 2 * COL_BITS;
   localparam int DEPTH     = 1 << ADDR_BITS;
   localparam int ENTRY_BITS = PROB_FRACTION_BITS + 1;

   localparam logic [ENTRY_BITS-1:0] PROB_ONE = {1'b1, {PROB_FRACTION_BITS{1'b0}}};

   // Rows and columns padded to a power of two: address = {row, column}
   logic [ENTRY_BITS-1:0] mem [DEPTH];

   logic                  sweep_ff;
   logic                  sweep_in;
   logic [ADDR_BITS-1:0]  sweep_addr_ff;
   logic [ADDR_BITS-1:0]  sweep_addr_in;
   logic [ENTRY_BITS-1:0] rd_data_ff;

   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_addr;
   logic [ENTRY_BITS-1:0] mem_data;

   // Identity sweep: one entry per cycle, diagonal gets one
   always_comb begin
      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
         if (sweep_addr_ff == {ADDR_BITS{1'b1}}) begin
            sweep_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   // Write port: sweep has priority (no items are taken while it runs)
   always_comb begin
      if (sweep_ff) begin
         mem_we   = 1'b1;
         mem_addr = sweep_addr_ff;
         mem_data = (sweep_addr_ff[ADDR_BITS-1:COL_BITS] == sweep_addr_ff[COL_BITS-1:0])
                    ? PROB_ONE : '0;
      end else begin
         mem_we   = wr_en;
         mem_addr = wr_addr;
         mem_data = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = sweep_ff;

endmodule

@@ sv/mnss_walk.sv @@
// ----------------------------------------------------------------------------
// mnss_walk
// Row walk datapath: accumulates the entries of one row as they come out of
// the table and flags the first column whose running sum exceeds alpha.
// ----------------------------------------------------------------------------
module mnss_walk #(
   parameter int STATES             = mnss_pkg::DEFAULT_STATES,
   parameter int PROB_FRACTION_BITS = mnss_pkg::DEFAULT_PROB_FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mnss_pkg::ALPHA_BITS-1:0]   alpha,
   input  logic                              rd_fire,
   input  logic [$clog2(STATES)-1:0]         rd_col,
   input  logic [PROB_FRACTION_BITS:0]       rd_data,
   output mnss_pkg::walk_status_type         status
);

   localparam int COL_BITS   = $clog2(STATES);
   localparam int ENTRY_BITS = PROB_FRACTION_BITS + 1;
   localparam int SUM_BITS   = ENTRY_BITS + COL_BITS;
   localparam int CMP_BITS   = SUM_BITS + mnss_pkg::ALPHA_BITS;

   localparam logic [COL_BITS-1:0] LAST_COL = COL_BITS'(STATES - 1);

   logic                            vld_ff;
   logic [COL_BITS-1:0]             col_ff;
   logic [SUM_BITS-1:0]             sum_ff;
   logic [SUM_BITS-1:0]             sum_in;
   logic [mnss_pkg::ALPHA_BITS-1:0] alpha_ff;
   logic [CMP_BITS-1:0]             lhs;
   logic [CMP_BITS-1:0]             rhs;
   logic                            hit;
   logic                            last;

   // Track which column the read data belongs to
   always_ff @(posedge clock) begin
      if (reset || start) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= rd_fire;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= rd_col;
   end

   // Running sum and exact compare: alpha * 2^P < sum * 2^16
   assign sum_in = sum_ff + SUM_BITS'(rd_data);
   assign lhs    = CMP_BITS'(alpha_ff) << PROB_FRACTION_BITS;
   assign rhs    = CMP_BITS'(sum_in) << mnss_pkg::ALPHA_BITS;
   assign hit    = vld_ff && (lhs < rhs);
   assign last   = vld_ff && (col_ff == LAST_COL);

   always_ff @(posedge clock) begin
      if (start) begin
         sum_ff   <= '0;
         alpha_ff <= alpha;
      end else if (vld_ff) begin
         sum_ff   <= sum_in;
      end
   end

   // Status towards the sequencer
   always_comb begin
      status.done         = hit || last;
      status.fell_through = !hit;
      status.next_state   = hit ? mnss_pkg::NEXT_BITS'(col_ff)
                                : mnss_pkg::NEXT_BITS'(STATES - 1);
   end

endmodule

@@ sv/markov_next_state_sampler_core.sv @@
// ----------------------------------------------------------------------------
// markov_next_state_sampler_core
// Inverse-CDF sampler over a transition table held in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_ch    in    valid / ready  operation, row_state, column_state,
//                                 probability, alpha
//  rsp_ch    out   valid / ready  next_state, fell_through
//
//  A write item leaves the sampler ready for the next item. A sample item
//  reads its row one entry per cycle through the table's single read port;
//  its result is held in a pending register, then in the response register.
//  After reset the table is loaded with the identity matrix, one entry per
//  cycle over 4**clog2(STATES) entries (256 at 16 states); no item is taken
//  meanwhile. A waiting response does not block acceptance of the next
//  item; only the hand-over of a new result waits for the response register.
// ----------------------------------------------------------------------------
module markov_next_state_sampler_core #(
   parameter int STATES             = mnss_pkg::DEFAULT_STATES,
   parameter int PROB_FRACTION_BITS = mnss_pkg::DEFAULT_PROB_FRACTION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   mnss_req_if.sink          req_ch,
   mnss_rsp_if.source        rsp_ch
);

   localparam int COL_BITS   = $clog2(STATES);
   localparam int ADDR_BITS  = 2 * COL_BITS;
   localparam int ENTRY_BITS = PROB_FRACTION_BITS + 1;
   localparam int SAT_BITS   = (ENTRY_BITS > mnss_pkg::PROB_BITS)
                               ? ENTRY_BITS : mnss_pkg::PROB_BITS;

   localparam logic [ENTRY_BITS-1:0] PROB_ONE = {1'b1, {PROB_FRACTION_BITS{1'b0}}};
   localparam logic [COL_BITS-1:0]   LAST_COL = COL_BITS'(STATES - 1);

   mnss_pkg::ctrl_state_type state_ff;
   mnss_pkg::ctrl_state_type state_in;

   logic                             accept;
   logic                             is_sample;
   logic                             row_ok;
   logic                             col_ok;
   logic                             start;
   logic                             rd_fire;
   logic                             out_free;
   logic                             tbl_busy;
   logic [ENTRY_BITS-1:0]            wr_data;
   logic [ENTRY_BITS-1:0]            rd_data;
   mnss_pkg::walk_status_type        walk_status;

   logic [COL_BITS-1:0]              row_ff;
   logic [COL_BITS-1:0]              issue_col_ff;
   logic                             issue_done_ff;
   logic [mnss_pkg::NEXT_BITS-1:0]   pend_next_ff;
   logic                             pend_fell_ff;
   logic                             rsp_valid_ff;
   logic [mnss_pkg::NEXT_BITS-1:0]   rsp_next_ff;
   logic                             rsp_fell_ff;

   // Request decode
   assign accept    = req_ch.valid && req_ch.ready;
   assign is_sample = (req_ch.operation == mnss_pkg::OP_SAMPLE);
   assign row_ok    = (32'(req_ch.row_state) < STATES);
   assign col_ok    = (32'(req_ch.column_state) < STATES);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   // Saturate written probabilities to one
   assign wr_data = (SAT_BITS'(req_ch.probability) > SAT_BITS'(PROB_ONE))
                    ? PROB_ONE : ENTRY_BITS'(req_ch.probability);

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mnss_pkg::ST_CLEAR: begin
            if (!tbl_busy) state_in = mnss_pkg::ST_IDLE;
         end
         mnss_pkg::ST_IDLE: begin
            if (accept && is_sample) begin
               state_in = row_ok ? mnss_pkg::ST_WALK : mnss_pkg::ST_HOLD;
            end
         end
         mnss_pkg::ST_WALK: begin
            if (walk_status.done) state_in = mnss_pkg::ST_HOLD;
         end
         mnss_pkg::ST_HOLD: begin
            if (out_free) state_in = mnss_pkg::ST_IDLE;
         end
         default: state_in = mnss_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mnss_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer: outputs
   always_comb begin
      req_ch.ready = 1'b0;
      start        = 1'b0;
      rd_fire      = 1'b0;
      unique case (state_ff)
         mnss_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            start        = accept && is_sample && row_ok;
         end
         mnss_pkg::ST_WALK: begin
            rd_fire = !issue_done_ff;
         end
         mnss_pkg::ST_CLEAR, mnss_pkg::ST_HOLD: begin
            req_ch.ready = 1'b0;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // Row read issue: one column per cycle until the last
   always_ff @(posedge clock) begin
      if (start) begin
         row_ff <= COL_BITS'(req_ch.row_state);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_col_ff  <= '0;
         issue_done_ff <= 1'b0;
      end else if (start) begin
         issue_col_ff  <= '0;
         issue_done_ff <= 1'b0;
      end else if (rd_fire) begin
         issue_col_ff  <= issue_col_ff + 1'b1;
         issue_done_ff <= (issue_col_ff == LAST_COL);
      end
   end

   // Pending result, waiting for the response register
   always_ff @(posedge clock) begin
      if (state_ff == mnss_pkg::ST_IDLE && accept && is_sample && !row_ok) begin
         pend_next_ff <= mnss_pkg::NEXT_BITS'(STATES - 1);
         pend_fell_ff <= 1'b1;
      end else if (state_ff == mnss_pkg::ST_WALK && walk_status.done) begin
         pend_next_ff <= walk_status.next_state;
         pend_fell_ff <= walk_status.fell_through;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == mnss_pkg::ST_HOLD && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mnss_pkg::ST_HOLD && out_free) begin
         rsp_next_ff <= pend_next_ff;
         rsp_fell_ff <= pend_fell_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.next_state   = rsp_next_ff;
   assign rsp_ch.fell_through = rsp_fell_ff;

   // Transition table
   mnss_table #(
      .STATES             (STATES),
      .PROB_FRACTION_BITS (PROB_FRACTION_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && !is_sample && row_ok && col_ok),
      .wr_addr ({COL_BITS'(req_ch.row_state), COL_BITS'(req_ch.column_state)}),
      .wr_data (wr_data),
      .rd_en   (rd_fire),
      .rd_addr ({row_ff, issue_col_ff}),
      .rd_data (rd_data),
      .busy    (tbl_busy)
   );

   // Row walk
   mnss_walk #(
      .STATES             (STATES),
      .PROB_FRACTION_BITS (PROB_FRACTION_BITS)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .alpha   (req_ch.alpha),
      .rd_fire (rd_fire),
      .rd_col  (issue_col_ff),
      .rd_data (rd_data),
      .status  (walk_status)
   );

endmodule
